>>> rtl/core/rgba_bf_pkg.sv
// Shared constants and types for the RGBA box-filter downscaler.
`timescale 1ns / 1ps
`default_nettype none
package rgba_bf_pkg;

  localparam int DEF_MAX_DEST_EDGE   = 256;
  localparam int DEF_MAX_SOURCE_EDGE = 4096;

  localparam int PIX_W      = 8;
  localparam int NUM_CHAN   = 4;
  localparam int COORD_W    = 12;
  localparam int SRC_CFG_W  = 13;
  localparam int EDGE_CFG_W = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EDGE      = 2'd2;

  // per-item control from the sequencer to every channel lane
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_zero;
    logic entry_valid;
    logic avg_go;
  } lane_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/core/rgba_bf_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module rgba_bf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WIDTH-1:0]      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/rgba_bf_div.sv
// Restoring divider, one quotient bit per cycle, for the geometry sums.
`timescale 1ns / 1ps
`default_nettype none
module rgba_bf_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 14
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] q,
  output logic                  done
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        rem   <= '0;
        q     <= num;
        den_r <= den;
        cnt   <= CW'(NUM_W);
        busy  <= 1'b1;
      end else if (busy) begin
        rem <= fits ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
        q   <= {q[NUM_W-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/rgba_bf_lane.sv
// One colour channel: column accumulator memory and average divider.
`timescale 1ns / 1ps
`default_nettype none
module rgba_bf_lane #(
  parameter int DEPTH = 256,
  parameter int N_W   = 26,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire rgba_bf_pkg::lane_ctrl_t           ctl,
  input  wire logic [AW-1:0]                     addr,
  input  wire logic [rgba_bf_pkg::PIX_W-1:0]     pix,
  input  wire logic [N_W-1:0]                    n,
  output logic      [rgba_bf_pkg::PIX_W-1:0]     avg,
  output logic                                   done
);
  localparam int PW    = rgba_bf_pkg::PIX_W;
  localparam int SUM_W = PW + N_W;
  localparam int CW    = $clog2(PW + 1);

  logic [SUM_W-1:0] rdata;
  logic [SUM_W-1:0] sum_new;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] rem;
  logic [SUM_W-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             fits;

  assign sum_new = (ctl.entry_valid ? rdata : '0) + SUM_W'(pix);
  assign fits    = (rem >= dsr);

  rgba_bf_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (addr),
    .wdata (ctl.wr_zero ? '0 : sum_new),
    .re    (ctl.rd_en),
    .raddr (addr),
    .rdata (rdata)
  );

  // quotient is known to stay below 256, so only eight steps are needed
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.wr_en) begin
        acc <= sum_new;
      end
      if (ctl.avg_go) begin
        rem  <= acc;
        dsr  <= SUM_W'(n) << (PW - 1);
        cnt  <= CW'(PW);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= rem - dsr;
        end
        avg <= {avg[PW-2:0], fits};
        dsr <= dsr >> 1;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/rgba_box_filter_downscaler.sv
// Top level: RGBA box-filter downscaler with per-channel lanes and sequencer.
// Pixels are taken one item at a time (in_stall is high outside idle); a cell end adds an
//   eight-step lane divide, and each boundary adds a divide (one at a column end, two at a
//   cell-row end); frame start adds four divides when averaging.
// Reset (sync, active high): state, counters, valid bits, out_valid cleared; 4096x4096, limit 256.
`timescale 1ns / 1ps
`default_nettype none
module rgba_box_filter_downscaler #(
  parameter int MAX_DEST_EDGE   = rgba_bf_pkg::DEF_MAX_DEST_EDGE,
  parameter int MAX_SOURCE_EDGE = rgba_bf_pkg::DEF_MAX_SOURCE_EDGE
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // pixel input
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [rgba_bf_pkg::PIX_W-1:0]         red,
  input  wire logic [rgba_bf_pkg::PIX_W-1:0]         green,
  input  wire logic [rgba_bf_pkg::PIX_W-1:0]         blue,
  input  wire logic [rgba_bf_pkg::PIX_W-1:0]         alpha,
  // result output
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic      [rgba_bf_pkg::PIX_W-1:0]         out_red,
  output logic      [rgba_bf_pkg::PIX_W-1:0]         out_green,
  output logic      [rgba_bf_pkg::PIX_W-1:0]         out_blue,
  output logic      [rgba_bf_pkg::PIX_W-1:0]         out_alpha,
  output logic      [rgba_bf_pkg::COORD_W-1:0]       out_col,
  output logic      [rgba_bf_pkg::COORD_W-1:0]       out_row,
  output logic                                       frame_last,
  // configuration writes
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [rgba_bf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rgba_bf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  localparam int PW    = rgba_bf_pkg::PIX_W;
  localparam int NCH   = rgba_bf_pkg::NUM_CHAN;
  localparam int CRW   = rgba_bf_pkg::COORD_W;
  localparam int SCW   = rgba_bf_pkg::SRC_CFG_W;
  localparam int ECW   = rgba_bf_pkg::EDGE_CFG_W;
  localparam int SW    = $clog2(MAX_SOURCE_EDGE + 1);   // source edge incl. max
  localparam int DW    = $clog2(MAX_DEST_EDGE + 1);     // dest edge incl. max
  localparam int AW    = (MAX_DEST_EDGE > 1) ? $clog2(MAX_DEST_EDGE) : 1;
  localparam int NUM_W = SW + DW + 1;                   // 2*edge*m + longest
  localparam int DEN_W = SW + 1;                        // 2*longest
  localparam int N_W   = 2 * SW;                        // cell pixel count

  typedef enum logic [4:0] {
    S_IDLE, S_LAT, S_GEOM, S_DW, S_DH, S_CB0, S_RB0, S_ROUTE, S_RD, S_ACC,
    S_N, S_AVGGO, S_AVG, S_EMIT, S_UPD, S_RB_MUL, S_RB, S_CB_MUL, S_CB, S_ADV
  } state_t;

  state_t state;

  // configuration registers
  logic [SCW-1:0] src_w_reg;
  logic [SCW-1:0] src_h_reg;
  logic [ECW-1:0] max_edge_reg;

  // frame geometry latched at the first pixel
  logic [SW-1:0]  lat_w, lat_h, longest;
  logic [DW-1:0]  m_lat;
  logic           pass;
  logic [DW-1:0]  dest_w, dest_h;

  // position tracking
  logic [SW-1:0]  src_col, src_row;
  logic [DW-1:0]  dst_col, dst_row;
  logic [SW-1:0]  col_b, row_b;     // exclusive source end of current cell
  logic [SW-1:0]  col_s, row_s;     // source start of current cell

  logic [PW-1:0]  pix_r [NCH];
  logic [SW-1:0]  cw_r, ch_r;
  logic [N_W-1:0] n_r;
  logic [MAX_DEST_EDGE-1:0] ent_valid;

  // shared divider
  logic             div_go;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_q;
  logic             div_done;

  // lanes
  rgba_bf_pkg::lane_ctrl_t lane_ctl;
  logic [PW-1:0]  lane_avg [NCH];
  logic [NCH-1:0] lane_done;

  // clamped register values
  logic [SW-1:0]  w_cl, h_cl;
  logic [DW-1:0]  m_cl;

  logic [SW-1:0]  sc1, sr1;
  logic [DW-1:0]  dc1, dr1;
  logic [AW-1:0]  dst_addr;
  logic           cell_end;
  logic           out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  assign sc1      = src_col + SW'(1);
  assign sr1      = src_row + SW'(1);
  assign dc1      = dst_col + DW'(1);
  assign dr1      = dst_row + DW'(1);
  assign dst_addr = AW'(dst_col);
  assign cell_end = (sc1 == col_b) && (sr1 == row_b);

  // saturate zero and oversized values
  always_comb begin
    if (src_w_reg == '0) begin
      w_cl = SW'(1);
    end else if (32'(src_w_reg) > MAX_SOURCE_EDGE) begin
      w_cl = SW'(MAX_SOURCE_EDGE);
    end else begin
      w_cl = SW'(src_w_reg);
    end
    if (src_h_reg == '0) begin
      h_cl = SW'(1);
    end else if (32'(src_h_reg) > MAX_SOURCE_EDGE) begin
      h_cl = SW'(MAX_SOURCE_EDGE);
    end else begin
      h_cl = SW'(src_h_reg);
    end
    if (max_edge_reg == '0) begin
      m_cl = DW'(1);
    end else if (32'(max_edge_reg) > MAX_DEST_EDGE) begin
      m_cl = DW'(MAX_DEST_EDGE);
    end else begin
      m_cl = DW'(max_edge_reg);
    end
  end

  // lane strobes follow the sequencer state
  always_comb begin
    lane_ctl             = '0;
    lane_ctl.rd_en       = (state == S_RD);
    lane_ctl.wr_en       = (state == S_ACC);
    lane_ctl.wr_zero     = cell_end;
    lane_ctl.entry_valid = ent_valid[dst_addr];
    lane_ctl.avg_go      = (state == S_AVGGO);
  end

  rgba_bf_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .q    (div_q),
    .done (div_done)
  );

  for (genvar i = 0; i < NCH; i++) begin : g_lane
    rgba_bf_lane #(.DEPTH(MAX_DEST_EDGE), .N_W(N_W)) u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctl  (lane_ctl),
      .addr (dst_addr),
      .pix  (pix_r[i]),
      .n    (n_r),
      .avg  (lane_avg[i]),
      .done (lane_done[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      div_go       <= 1'b0;
      ent_valid    <= '0;
      src_w_reg    <= SCW'(4096);
      src_h_reg    <= SCW'(4096);
      max_edge_reg <= ECW'(256);
      src_col      <= '0;
      src_row      <= '0;
      dst_col      <= '0;
      dst_row      <= '0;
      col_b        <= '0;
      row_b        <= '0;
      col_s        <= '0;
      row_s        <= '0;
      dest_w       <= '0;
      dest_h       <= '0;
      lat_w        <= '0;
      lat_h        <= '0;
      pass         <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          rgba_bf_pkg::REG_SOURCE_WIDTH:  src_w_reg    <= cfg_data;
          rgba_bf_pkg::REG_SOURCE_HEIGHT: src_h_reg    <= cfg_data;
          rgba_bf_pkg::REG_MAX_EDGE:      max_edge_reg <= ECW'(cfg_data);
          default: ;  // unknown index, write dropped
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pix_r[0] <= red;
            pix_r[1] <= green;
            pix_r[2] <= blue;
            pix_r[3] <= alpha;
            state    <= (src_col == '0 && src_row == '0) ? S_LAT : S_ROUTE;
          end
        end

        // frame start: latch geometry
        S_LAT: begin
          lat_w   <= w_cl;
          lat_h   <= h_cl;
          m_lat   <= m_cl;
          pass    <= (32'(w_cl) <= 32'(m_cl)) && (32'(h_cl) <= 32'(m_cl));
          longest <= (w_cl > h_cl) ? w_cl : h_cl;
          dst_col <= '0;
          dst_row <= '0;
          col_s   <= '0;
          row_s   <= '0;
          state   <= S_GEOM;
        end
        S_GEOM: begin
          if (pass) begin
            dest_w <= DW'(lat_w);
            dest_h <= DW'(lat_h);
            col_b  <= SW'(1);
            row_b  <= SW'(1);
            state  <= S_ROUTE;
          end else begin
            // round half up: (2*w*m + L) / (2*L)
            div_num <= ((NUM_W'(lat_w) * NUM_W'(m_lat)) << 1) + NUM_W'(longest);
            div_den <= {longest, 1'b0};
            div_go  <= 1'b1;
            state   <= S_DW;
          end
        end
        S_DW: begin
          if (div_done) begin
            dest_w  <= (div_q == '0) ? DW'(1) : DW'(div_q);
            div_num <= ((NUM_W'(lat_h) * NUM_W'(m_lat)) << 1) + NUM_W'(longest);
            div_den <= {longest, 1'b0};
            div_go  <= 1'b1;
            state   <= S_DH;
          end
        end
        S_DH: begin
          if (div_done) begin
            dest_h  <= (div_q == '0) ? DW'(1) : DW'(div_q);
            div_num <= NUM_W'(lat_w);
            div_den <= DEN_W'(dest_w);
            div_go  <= 1'b1;
            state   <= S_CB0;
          end
        end
        S_CB0: begin
          if (div_done) begin
            col_b   <= SW'(div_q);
            div_num <= NUM_W'(lat_h);
            div_den <= DEN_W'(dest_h);
            div_go  <= 1'b1;
            state   <= S_RB0;
          end
        end
        S_RB0: begin
          if (div_done) begin
            row_b <= SW'(div_q);
            state <= S_ROUTE;
          end
        end

        S_ROUTE: begin
          if (!pass) begin
            state <= S_RD;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            out_red    <= pix_r[0];
            out_green  <= pix_r[1];
            out_blue   <= pix_r[2];
            out_alpha  <= pix_r[3];
            out_col    <= CRW'(src_col);
            out_row    <= CRW'(src_row);
            frame_last <= (sc1 == lat_w) && (sr1 == lat_h);
            state      <= S_ADV;
          end
        end

        // accumulate into the column entry
        S_RD: state <= S_ACC;
        S_ACC: begin
          ent_valid[dst_addr] <= 1'b1;
          cw_r  <= col_b - col_s;
          ch_r  <= row_b - row_s;
          state <= cell_end ? S_N : S_UPD;
        end
        S_N: begin
          n_r   <= N_W'(cw_r) * N_W'(ch_r);
          state <= S_AVGGO;
        end
        S_AVGGO: state <= S_AVG;
        S_AVG: begin
          if (&lane_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_red    <= lane_avg[0];
            out_green  <= lane_avg[1];
            out_blue   <= lane_avg[2];
            out_alpha  <= lane_avg[3];
            out_col    <= CRW'(dst_col);
            out_row    <= CRW'(dst_row);
            frame_last <= (dc1 == dest_w) && (dr1 == dest_h);
            state      <= S_UPD;
          end
        end

        // advance the destination cell
        S_UPD: begin
          if (sc1 == col_b) begin
            if (sc1 >= lat_w) begin
              dst_col <= '0;
              col_s   <= '0;
              if (sr1 == row_b) begin
                if (dr1 < dest_h) begin
                  dst_row <= dr1;
                  row_s   <= row_b;
                end else begin
                  dst_row <= '0;
                  row_s   <= '0;
                end
                state <= S_RB_MUL;
              end else begin
                state <= S_CB_MUL;
              end
            end else begin
              dst_col <= dc1;
              col_s   <= col_b;
              state   <= S_CB_MUL;
            end
          end else begin
            state <= S_ADV;
          end
        end
        S_RB_MUL: begin
          div_num <= (NUM_W'(dst_row) + NUM_W'(1)) * NUM_W'(lat_h);
          div_den <= DEN_W'(dest_h);
          div_go  <= 1'b1;
          state   <= S_RB;
        end
        S_RB: begin
          if (div_done) begin
            row_b <= SW'(div_q);
            state <= S_CB_MUL;
          end
        end
        S_CB_MUL: begin
          div_num <= (NUM_W'(dst_col) + NUM_W'(1)) * NUM_W'(lat_w);
          div_den <= DEN_W'(dest_w);
          div_go  <= 1'b1;
          state   <= S_CB;
        end
        S_CB: begin
          if (div_done) begin
            col_b <= SW'(div_q);
            state <= S_ADV;
          end
        end

        // source position, wraps after the frame's last pixel
        S_ADV: begin
          if (sc1 >= lat_w) begin
            src_col <= '0;
            src_row <= (sr1 >= lat_h) ? '0 : sr1;
          end else begin
            src_col <= sc1;
          end
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire
